// File: hw/rtl/i2cep_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM paged master package
// Shared sizes, codes, item layouts and helper functions for the paged
// EEPROM master and its submodules.
// ----------------------------------------------------------------------------
package i2cep_pkg;

  // Memory geometry and retry limit.
  localparam int PAGE_BYTES   = 32;
  localparam int MEM_BYTES    = 4096;
  localparam int MAX_ATTEMPTS = 2;

  // Field and state widths.
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int SUM_W      = COUNT_W + 1;
  localparam int WAIT_W     = 20;
  localparam int CADDR_W    = 16;
  localparam int PAGE_IDX_W = $clog2(PAGE_BYTES);
  localparam int CHUNK_W    = $clog2(PAGE_BYTES + 1);
  localparam int SLOT_W     = $clog2(PAGE_BYTES + 4);
  localparam int BITCNT_W   = 4;
  localparam int ATT_W      = 2;
  localparam int CFG_IDX_W  = 2;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  // Request outcome codes.
  typedef enum logic [1:0] {
    OC_OK     = 2'd0,
    OC_REJECT = 2'd1,
    OC_NACK   = 2'd2
  } outcome_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_CTRL = 2'd0,
    CFG_READ_CTRL  = 2'd1,
    CFG_WAIT_TICKS = 2'd2
  } cfg_idx_t;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_FILL      = 5'd1,
    PH_START_A   = 5'd2,
    PH_START_B   = 5'd3,
    PH_TX_LOW    = 5'd4,
    PH_TX_HIGH   = 5'd5,
    PH_RX_LOW    = 5'd6,
    PH_RX_HIGH   = 5'd7,
    PH_MACK_LOW  = 5'd8,
    PH_MACK_HIGH = 5'd9,
    PH_RS_A      = 5'd10,
    PH_RS_B      = 5'd11,
    PH_RS_C      = 5'd12,
    PH_STOP_A    = 5'd13,
    PH_STOP_B    = 5'd14,
    PH_STOP_C    = 5'd15,
    PH_WAIT      = 5'd16
  } phase_t;

  // One input item.
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  mem_address;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  write_byte;
    logic               sda_sample;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              protect_pin;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              read_last;
    logic              want_byte;
    logic              busy_res;
    logic              finished;
    outcome_t          outcome;
  } result_t;

  // Configuration register set.
  typedef struct packed {
    logic [BYTE_W-1:0] write_ctrl;
    logic [BYTE_W-1:0] read_ctrl;
    logic [WAIT_W-1:0] wait_ticks;
  } cfg_t;

  // Page buffer write port.
  typedef struct packed {
    logic                  en;
    logic [PAGE_IDX_W-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } pbuf_wr_t;

  // Length of the next chunk: up to the page boundary, limited by what is left.
  function automatic logic [CHUNK_W-1:0] chunk_len(input logic [CADDR_W-1:0] addr,
                                                   input logic [COUNT_W-1:0] left_total);
    logic [CHUNK_W-1:0] to_edge;
    to_edge = CHUNK_W'(PAGE_BYTES) - {1'b0, addr[PAGE_IDX_W-1:0]};
    if (left_total < COUNT_W'(to_edge)) begin
      return left_total[CHUNK_W-1:0];
    end
    return to_edge;
  endfunction

endpackage

// File: hw/rtl/i2cep_pbuf.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port memory with a registered read.
// ----------------------------------------------------------------------------
module i2cep_pbuf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; the read data is registered and follows the address in the next cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/i2cep_core.sv
// ----------------------------------------------------------------------------
// Bus sequencer
// Holds the request and bus state and advances it by one item per step:
// request checks, chunking, page fill, bit timing, acknowledges and waits.
// ----------------------------------------------------------------------------
module i2cep_core import i2cep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  item_t                 item,
  input  cfg_t                  cfg,
  output result_t               result,
  output pbuf_wr_t              pb_wr,
  output logic [PAGE_IDX_W-1:0] pb_rd_addr,
  input  logic [BYTE_W-1:0]     pb_rd_data
);

  // State registers.
  phase_t               phase, phase_next;
  logic [BITCNT_W-1:0]  bit_counter, bit_counter_next;
  logic [BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic [CADDR_W-1:0]   current_address, current_address_next;
  logic [COUNT_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [CHUNK_W-1:0]   chunk_length, chunk_length_next;
  logic [CHUNK_W-1:0]   chunk_index, chunk_index_next;
  logic [ATT_W-1:0]     attempt_count, attempt_count_next;
  logic                 nack_seen, nack_seen_next;
  logic [WAIT_W-1:0]    wait_counter, wait_counter_next;
  logic                 is_read, is_read_next;
  logic [SLOT_W-1:0]    byte_slot, byte_slot_next;
  logic                 scl_q, scl_q_next;
  logic                 sda_q, sda_q_next;
  logic                 drv_q, drv_q_next;

  // Helper values.
  logic [SUM_W-1:0]     req_end;
  logic [SLOT_W-1:0]    slot_inc;
  logic [SLOT_W-1:0]    pb_idx;
  logic                 pb_ok;
  logic [CHUNK_W-1:0]   ci_inc;
  logic [BITCNT_W-1:0]  bc_inc;
  logic [BYTE_W-1:0]    rx_shift;
  logic [COUNT_W-1:0]   br_dec;
  logic [WAIT_W-1:0]    wc_dec;
  logic [CADDR_W-1:0]   addr_adv;
  logic [COUNT_W-1:0]   br_adv;
  logic                 nack_now;
  logic                 rd_byte_valid;
  logic [BYTE_W-1:0]    rd_byte;
  logic                 rd_last;
  logic                 fin;
  outcome_t             oc;

  // Byte to send in a given slot of the transfer.
  function automatic logic [BYTE_W-1:0] slot_value(input logic [SLOT_W-1:0] slot,
                                                   input logic rd,
                                                   input cfg_t c,
                                                   input logic [CADDR_W-1:0] a,
                                                   input logic ok,
                                                   input logic [BYTE_W-1:0] pb);
    if (slot == SLOT_W'(0)) return c.write_ctrl;
    if (slot == SLOT_W'(1)) return a[CADDR_W-1:BYTE_W];
    if (slot == SLOT_W'(2)) return a[BYTE_W-1:0];
    if (rd) return c.read_ctrl;
    return ok ? pb : '0;
  endfunction

  // Page buffer addressing: only the slot after the current one is ever read.
  assign slot_inc   = byte_slot + SLOT_W'(1);
  assign pb_idx     = byte_slot - SLOT_W'(2);
  assign pb_ok      = pb_idx < SLOT_W'(PAGE_BYTES);
  assign pb_rd_addr = pb_idx[PAGE_IDX_W-1:0];

  // Arithmetic shared by several phases.
  assign req_end  = SUM_W'(item.mem_address) + SUM_W'(item.byte_count);
  assign ci_inc   = chunk_index + CHUNK_W'(1);
  assign bc_inc   = bit_counter + BITCNT_W'(1);
  assign rx_shift = {shift_byte[BYTE_W-2:0], item.sda_sample};
  assign br_dec   = (bytes_remaining != '0) ? bytes_remaining - COUNT_W'(1) : bytes_remaining;
  assign wc_dec   = (wait_counter != '0) ? wait_counter - WAIT_W'(1) : wait_counter;
  assign addr_adv = current_address + CADDR_W'(chunk_length);
  assign br_adv   = (bytes_remaining >= COUNT_W'(chunk_length)) ?
                    bytes_remaining - COUNT_W'(chunk_length) : '0;
  assign nack_now = nack_seen | item.sda_sample;

  // Next state and result of one item.
  always_comb begin
    phase_next           = phase;
    bit_counter_next     = bit_counter;
    shift_byte_next      = shift_byte;
    current_address_next = current_address;
    bytes_remaining_next = bytes_remaining;
    chunk_length_next    = chunk_length;
    chunk_index_next     = chunk_index;
    attempt_count_next   = attempt_count;
    nack_seen_next       = nack_seen;
    wait_counter_next    = wait_counter;
    is_read_next         = is_read;
    byte_slot_next       = byte_slot;
    scl_q_next           = scl_q;
    sda_q_next           = sda_q;
    drv_q_next           = drv_q;
    rd_byte_valid        = 1'b0;
    rd_byte              = '0;
    rd_last              = 1'b0;
    fin                  = 1'b0;
    oc                   = OC_OK;
    pb_wr.en             = 1'b0;
    pb_wr.addr           = chunk_index[PAGE_IDX_W-1:0];
    pb_wr.data           = item.write_byte;

    if (phase == PH_IDLE) begin
      // New request: check bounds, then start a read or the first chunk.
      if (item.op == OP_WRITE || item.op == OP_READ) begin
        if (item.byte_count == '0 || req_end > SUM_W'(MEM_BYTES)) begin
          fin = 1'b1;
          oc  = OC_REJECT;
        end else begin
          current_address_next = CADDR_W'(item.mem_address);
          bytes_remaining_next = item.byte_count;
          attempt_count_next   = '0;
          nack_seen_next       = 1'b0;
          byte_slot_next       = '0;
          is_read_next         = (item.op == OP_READ);
          if (item.op == OP_READ) begin
            phase_next = PH_START_A;
          end else begin
            chunk_length_next = chunk_len(CADDR_W'(item.mem_address), item.byte_count);
            chunk_index_next  = '0;
            phase_next        = PH_FILL;
          end
        end
      end
    end else if (phase == PH_FILL) begin
      // Collect the chunk's bytes; ticks are ignored here.
      if (item.op == OP_BYTE) begin
        pb_wr.en         = chunk_index < CHUNK_W'(PAGE_BYTES);
        chunk_index_next = ci_inc;
        if (ci_inc >= chunk_length) begin
          attempt_count_next = '0;
          nack_seen_next     = 1'b0;
          byte_slot_next     = '0;
          phase_next         = PH_START_A;
        end
      end
    end else if (item.op == OP_TICK) begin
      unique case (phase)
        PH_START_A: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b111;
          phase_next = PH_START_B;
        end
        PH_START_B: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b101;
          shift_byte_next  = slot_value(byte_slot, is_read, cfg, current_address,
                                        pb_ok, pb_rd_data);
          bit_counter_next = '0;
          phase_next       = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          // Data bits, then release the line for the acknowledge.
          scl_q_next = 1'b0;
          if (bit_counter < BITCNT_W'(BYTE_W)) begin
            sda_q_next = shift_byte[BYTE_W-1];
            drv_q_next = 1'b1;
          end else begin
            sda_q_next = 1'b1;
            drv_q_next = 1'b0;
          end
          phase_next = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_q_next = 1'b1;
          if (bit_counter < BITCNT_W'(BYTE_W)) begin
            shift_byte_next  = {shift_byte[BYTE_W-2:0], 1'b0};
            bit_counter_next = bc_inc;
            phase_next       = PH_TX_LOW;
          end else begin
            // Acknowledge clock: pick the next slot or end the transfer.
            byte_slot_next = slot_inc;
            if (is_read) begin
              if (slot_inc == SLOT_W'(3)) begin
                phase_next = PH_RS_A;
              end else if (slot_inc >= SLOT_W'(4)) begin
                bit_counter_next = '0;
                shift_byte_next  = '0;
                phase_next       = PH_RX_LOW;
              end else begin
                shift_byte_next  = slot_value(slot_inc, is_read, cfg, current_address,
                                              pb_ok, pb_rd_data);
                bit_counter_next = '0;
                phase_next       = PH_TX_LOW;
              end
            end else begin
              nack_seen_next = nack_now;
              if (nack_now || slot_inc >= SLOT_W'(3) + SLOT_W'(chunk_length)) begin
                phase_next = PH_STOP_A;
              end else begin
                shift_byte_next  = slot_value(slot_inc, is_read, cfg, current_address,
                                              pb_ok, pb_rd_data);
                bit_counter_next = '0;
                phase_next       = PH_TX_LOW;
              end
            end
          end
        end
        PH_RS_A: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b011;
          phase_next = PH_RS_B;
        end
        PH_RS_B: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b111;
          phase_next = PH_RS_C;
        end
        PH_RS_C: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b101;
          shift_byte_next  = slot_value(byte_slot, is_read, cfg, current_address,
                                        pb_ok, pb_rd_data);
          bit_counter_next = '0;
          phase_next       = PH_TX_LOW;
        end
        PH_RX_LOW: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b010;
          phase_next = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          // Shift a bit in; a full byte goes out with this result.
          {scl_q_next, sda_q_next, drv_q_next} = 3'b110;
          shift_byte_next  = rx_shift;
          bit_counter_next = bc_inc;
          if (bc_inc >= BITCNT_W'(BYTE_W)) begin
            rd_byte       = rx_shift;
            rd_byte_valid = 1'b1;
            rd_last       = bytes_remaining <= COUNT_W'(1);
            phase_next    = PH_MACK_LOW;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
        PH_MACK_LOW: begin
          // ACK after each byte, NACK after the last one.
          scl_q_next = 1'b0;
          sda_q_next = bytes_remaining <= COUNT_W'(1);
          drv_q_next = 1'b1;
          phase_next = PH_MACK_HIGH;
        end
        PH_MACK_HIGH: begin
          scl_q_next           = 1'b1;
          bytes_remaining_next = br_dec;
          if (br_dec == '0) begin
            phase_next = PH_STOP_A;
          end else begin
            bit_counter_next = '0;
            shift_byte_next  = '0;
            phase_next       = PH_RX_LOW;
          end
        end
        PH_STOP_A: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b001;
          phase_next = PH_STOP_B;
        end
        PH_STOP_B: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b101;
          phase_next = PH_STOP_C;
        end
        PH_STOP_C: begin
          {scl_q_next, sda_q_next, drv_q_next} = 3'b111;
          if (is_read) begin
            fin        = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            wait_counter_next = cfg.wait_ticks;
            phase_next        = PH_WAIT;
          end
        end
        PH_WAIT: begin
          // Write cycle wait, then retry, fail, or move to the next chunk.
          wait_counter_next = wc_dec;
          if (wc_dec == '0) begin
            if (nack_seen) begin
              if (int'(attempt_count) + 1 < MAX_ATTEMPTS) begin
                attempt_count_next = attempt_count + ATT_W'(1);
                nack_seen_next     = 1'b0;
                byte_slot_next     = '0;
                phase_next         = PH_START_A;
              end else begin
                fin        = 1'b1;
                oc         = OC_NACK;
                phase_next = PH_IDLE;
              end
            end else begin
              current_address_next = addr_adv;
              bytes_remaining_next = br_adv;
              if (br_adv == '0) begin
                fin        = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                chunk_length_next = chunk_len(addr_adv, br_adv);
                chunk_index_next  = '0;
                phase_next        = PH_FILL;
              end
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    result.scl_level   = scl_q_next;
    result.sda_level   = sda_q_next;
    result.sda_drive   = drv_q_next;
    result.protect_pin = (phase_next == PH_IDLE);
    result.read_byte   = rd_byte;
    result.read_valid  = rd_byte_valid;
    result.read_last   = rd_last;
    result.want_byte   = (phase_next == PH_FILL);
    result.busy_res    = (phase_next != PH_IDLE);
    result.finished    = fin;
    result.outcome     = oc;
  end

  // State update, one step per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_counter     <= '0;
      shift_byte      <= '0;
      current_address <= '0;
      bytes_remaining <= '0;
      chunk_length    <= '0;
      chunk_index     <= '0;
      attempt_count   <= '0;
      nack_seen       <= 1'b0;
      wait_counter    <= '0;
      is_read         <= 1'b0;
      byte_slot       <= '0;
      scl_q           <= 1'b1;
      sda_q           <= 1'b1;
      drv_q           <= 1'b1;
    end else if (step) begin
      phase           <= phase_next;
      bit_counter     <= bit_counter_next;
      shift_byte      <= shift_byte_next;
      current_address <= current_address_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_length    <= chunk_length_next;
      chunk_index     <= chunk_index_next;
      attempt_count   <= attempt_count_next;
      nack_seen       <= nack_seen_next;
      wait_counter    <= wait_counter_next;
      is_read         <= is_read_next;
      byte_slot       <= byte_slot_next;
      scl_q           <= scl_q_next;
      sda_q           <= sda_q_next;
      drv_q           <= drv_q_next;
    end
  end

endmodule

// File: hw/rtl/i2c_eeprom_paged_master.sv
// ----------------------------------------------------------------------------
// I2C EEPROM paged master
// Page-chunked write and sequential read master for a 16-bit address EEPROM,
// stepped by tick and command items.
//
// Channel | Direction | Handshake            | Payload
// s       | in        | s_tvalid / s_tready  | s_tdata, s_tuser (op)
// m       | out       | m_tvalid / m_tready  | m_tdata, m_tuser, m_tlast
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per clock cycle is sustained while the output is not stalled. An item
// is captured in the input register, the sequencer takes one step on it
// when the result slot is free, and its result is held in the output register.
// The sequencer step is the only work per item. A stalled output holds the
// input register and stops the input side; in the cycle the waiting result
// is taken, a new item is taken as well. Reset needs no clearing pass; the
// configuration channel is always ready.
// ----------------------------------------------------------------------------
module i2c_eeprom_paged_master import i2cep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: mem_address[11:0], byte_count[24:12], write_byte[32:25],
  // sda_sample[33], zero padding[39:34]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]            s_tuser,
  // Result items.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: scl_level[0], sda_level[1], sda_drive[2], protect_pin[3],
  // read_byte[11:4], want_byte[12], busy_res[13], finished[14],
  // outcome[16:15], zero padding[23:17]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: read_valid[0]
  output logic                  m_tuser,
  output logic                  m_tlast,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WAIT_W-1:0]     cfg_data
);

  logic                  in_valid;
  item_t                 in_item;
  logic                  out_valid;
  result_t               out_res;
  logic                  step;
  cfg_t                  cfg;
  result_t               result;
  pbuf_wr_t              pb_wr;
  logic [PAGE_IDX_W-1:0] pb_rd_addr;
  logic [BYTE_W-1:0]     pb_rd_data;

  // The sequencer steps when an item waits and the result slot is free.
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op          <= op_t'(s_tuser);
      in_item.mem_address <= s_tdata[ADDR_W-1:0];
      in_item.byte_count  <= s_tdata[ADDR_W+COUNT_W-1:ADDR_W];
      in_item.write_byte  <= s_tdata[ADDR_W+COUNT_W+BYTE_W-1:ADDR_W+COUNT_W];
      in_item.sda_sample  <= s_tdata[ADDR_W+COUNT_W+BYTE_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_res.outcome, out_res.finished, out_res.busy_res,
                     out_res.want_byte, out_res.read_byte, out_res.protect_pin,
                     out_res.sda_drive, out_res.sda_level, out_res.scl_level};
  assign m_tuser  = out_res.read_valid;
  assign m_tlast  = out_res.read_last;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_ctrl <= 8'd160;
      cfg.read_ctrl  <= 8'd161;
      cfg.wait_ticks <= 20'd100000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WRITE_CTRL: cfg.write_ctrl <= cfg_data[BYTE_W-1:0];
        CFG_READ_CTRL:  cfg.read_ctrl  <= cfg_data[BYTE_W-1:0];
        CFG_WAIT_TICKS: cfg.wait_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and page buffer.
  i2cep_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_item),
    .cfg        (cfg),
    .result     (result),
    .pb_wr      (pb_wr),
    .pb_rd_addr (pb_rd_addr),
    .pb_rd_data (pb_rd_data)
  );

  // The read address only moves on an acknowledge step or when a transfer starts,
  // and is next used many steps later, so the registered read data is always settled by then.
  i2cep_pbuf #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_pbuf (
    .clk     (clk),
    .wr_en   (pb_wr.en),
    .wr_addr (pb_wr.addr),
    .wr_data (pb_wr.data),
    .rd_addr (pb_rd_addr),
    .rd_data (pb_rd_data)
  );

`ifndef SYNTHESIS
  // Write protect is released exactly while a request is in progress.
  a_protect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.protect_pin == !out_res.busy_res))
    else $error("protect_pin disagrees with busy_res");

  // A finished request leaves the block idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.finished) |-> !out_res.busy_res)
    else $error("request finished but block still busy");

  // Asking for write bytes only happens inside a request.
  a_want_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.want_byte) |-> out_res.busy_res)
    else $error("want_byte outside a request");

  // The last-byte mark only comes with a received byte.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.read_last) |-> out_res.read_valid)
    else $error("read_last without read_valid");
`endif

endmodule

// File: verif/i2cep_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C EEPROM paged master checker
// Watches the configuration, input and result channels of the paged master.
// Every accepted input item is run through a cycle-free copy of the
// sequencer. The result item it yields is queued, and each accepted result
// is compared field by field with the oldest one in the queue.
// ----------------------------------------------------------------------------
module i2cep_checker import i2cep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WAIT_W-1:0]     cfg_data,
  output int                    error_count,
  output int                    results_owed,
  output logic                  seq_idle,
  output logic                  seq_wants_byte
);

  // Register copies.
  logic [7:0]  wctrl;
  logic [7:0]  rctrl;
  logic [19:0] wait_ticks;

  // Sequencer copy.
  phase_t      phase;
  logic [3:0]  bits_sent;
  logic [7:0]  shreg;
  logic [15:0] ee_addr;
  logic [12:0] left_total;
  logic [5:0]  chunk_size;
  logic [5:0]  chunk_fill;
  logic [7:0]  page_mem [PAGE_BYTES];
  logic [1:0]  tries;
  logic        got_nack;
  logic [19:0] wait_left;
  logic        rd_req;
  logic [5:0]  slot;
  logic        line_scl;
  logic        line_sda;
  logic        line_oe;

  result_t     bus_results_due [$];
  int          results_seen;

  initial begin
    error_count = 0;
    results_owed = 0;
    results_seen = 0;
    seq_idle = 1'b1;
    seq_wants_byte = 1'b0;
  end

  task automatic drive_lines(input logic scl, input logic sda, input logic oe);
    line_scl = scl;
    line_sda = sda;
    line_oe  = oe;
  endtask

  // Chunk runs to the next page edge or to the end of the request.
  task automatic begin_chunk();
    logic [6:0] to_edge;
    to_edge = 7'(PAGE_BYTES - int'(ee_addr % PAGE_BYTES));
    chunk_size = (left_total < 13'(to_edge)) ? left_total[5:0] : to_edge[5:0];
    chunk_fill = '0;
    phase = PH_FILL;
  endtask

  // Byte order on the wire: control, address high, address low, then data
  // (or the read control byte after the repeated start).
  task automatic load_tx_byte();
    if (slot == 6'd0) shreg = wctrl;
    else if (slot == 6'd1) shreg = ee_addr[15:8];
    else if (slot == 6'd2) shreg = ee_addr[7:0];
    else if (rd_req) shreg = rctrl;
    else shreg = page_mem[5'(slot - 6'd3)];
    bits_sent = '0;
    phase = PH_TX_LOW;
  endtask

  // One sequencer step on one input item.
  task automatic step_eeprom_master(input item_t it, output result_t r);
    logic [13:0] span;
    logic        last_byte;
    r = '0;
    r.outcome = OC_OK;
    last_byte = (left_total < 13'd2);
    if (phase == PH_IDLE) begin
      if (it.op == OP_WRITE || it.op == OP_READ) begin
        span = {2'b00, it.mem_address} + {1'b0, it.byte_count};
        if (it.byte_count == '0 || span > 14'(MEM_BYTES)) begin
          r.finished = 1'b1;
          r.outcome = OC_REJECT;
        end else begin
          ee_addr = {4'b0000, it.mem_address};
          left_total = it.byte_count;
          tries = '0;
          got_nack = 1'b0;
          slot = '0;
          rd_req = (it.op == OP_READ);
          if (rd_req) phase = PH_START_A;
          else begin_chunk();
        end
      end
    end else if (phase == PH_FILL) begin
      if (it.op == OP_BYTE) begin
        page_mem[chunk_fill[4:0]] = it.write_byte;
        chunk_fill = chunk_fill + 6'd1;
        if (chunk_fill >= chunk_size) begin
          tries = '0;
          got_nack = 1'b0;
          slot = '0;
          phase = PH_START_A;
        end
      end
    end else if (it.op == OP_TICK) begin
      case (phase)
        PH_START_A: begin
          drive_lines(1'b1, 1'b1, 1'b1);
          phase = PH_START_B;
        end
        PH_START_B: begin
          drive_lines(1'b1, 1'b0, 1'b1);
          load_tx_byte();
        end
        PH_TX_LOW: begin
          // The ninth bit releases the line for the acknowledge.
          if (bits_sent < 4'd8) drive_lines(1'b0, shreg[7], 1'b1);
          else drive_lines(1'b0, 1'b1, 1'b0);
          phase = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          line_scl = 1'b1;
          if (bits_sent < 4'd8) begin
            shreg = {shreg[6:0], 1'b0};
            bits_sent = bits_sent + 4'd1;
            phase = PH_TX_LOW;
          end else begin
            slot = slot + 6'd1;
            if (rd_req) begin
              if (slot == 6'd3) phase = PH_RS_A;
              else if (slot >= 6'd4) begin
                bits_sent = '0;
                shreg = '0;
                phase = PH_RX_LOW;
              end else load_tx_byte();
            end else begin
              // Any acknowledge that comes back high ends the attempt.
              if (it.sda_sample) got_nack = 1'b1;
              if (got_nack || slot >= 6'd3 + chunk_size) phase = PH_STOP_A;
              else load_tx_byte();
            end
          end
        end
        PH_RS_A: begin
          drive_lines(1'b0, 1'b1, 1'b1);
          phase = PH_RS_B;
        end
        PH_RS_B: begin
          drive_lines(1'b1, 1'b1, 1'b1);
          phase = PH_RS_C;
        end
        PH_RS_C: begin
          drive_lines(1'b1, 1'b0, 1'b1);
          load_tx_byte();
        end
        PH_RX_LOW: begin
          drive_lines(1'b0, 1'b1, 1'b0);
          phase = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          drive_lines(1'b1, 1'b1, 1'b0);
          shreg = {shreg[6:0], it.sda_sample};
          bits_sent = bits_sent + 4'd1;
          if (bits_sent >= 4'd8) begin
            r.read_byte = shreg;
            r.read_valid = 1'b1;
            r.read_last = last_byte;
            phase = PH_MACK_LOW;
          end else phase = PH_RX_LOW;
        end
        PH_MACK_LOW: begin
          // ACK after each byte, NACK after the last one.
          drive_lines(1'b0, last_byte, 1'b1);
          phase = PH_MACK_HIGH;
        end
        PH_MACK_HIGH: begin
          line_scl = 1'b1;
          if (left_total != '0) left_total = left_total - 13'd1;
          if (left_total == '0) phase = PH_STOP_A;
          else begin
            bits_sent = '0;
            shreg = '0;
            phase = PH_RX_LOW;
          end
        end
        PH_STOP_A: begin
          drive_lines(1'b0, 1'b0, 1'b1);
          phase = PH_STOP_B;
        end
        PH_STOP_B: begin
          drive_lines(1'b1, 1'b0, 1'b1);
          phase = PH_STOP_C;
        end
        PH_STOP_C: begin
          drive_lines(1'b1, 1'b1, 1'b1);
          if (rd_req) begin
            r.finished = 1'b1;
            phase = PH_IDLE;
          end else begin
            wait_left = wait_ticks;
            phase = PH_WAIT;
          end
        end
        PH_WAIT: begin
          // A zero wait still costs this one tick.
          if (wait_left != '0) wait_left = wait_left - 20'd1;
          if (wait_left == '0) begin
            if (got_nack) begin
              if (int'(tries) + 1 < MAX_ATTEMPTS) begin
                tries = tries + 2'd1;
                got_nack = 1'b0;
                slot = '0;
                phase = PH_START_A;
              end else begin
                r.finished = 1'b1;
                r.outcome = OC_NACK;
                phase = PH_IDLE;
              end
            end else begin
              ee_addr = ee_addr + 16'(chunk_size);
              if (left_total >= 13'(chunk_size)) left_total = left_total - 13'(chunk_size);
              else left_total = '0;
              if (left_total == '0) begin
                r.finished = 1'b1;
                phase = PH_IDLE;
              end else begin_chunk();
            end
          end
        end
        default: phase = PH_IDLE;
      endcase
    end
    r.scl_level = line_scl;
    r.sda_level = line_sda;
    r.sda_drive = line_oe;
    r.protect_pin = (phase == PH_IDLE);
    r.want_byte = (phase == PH_FILL);
    r.busy_res = (phase != PH_IDLE);
  endtask

  // Compares one arriving result with the oldest one owed.
  task automatic check_result(input result_t act);
    result_t exp;
    string   diff;
    results_seen++;
    if (bus_results_due.size() == 0) begin
      error_count++;
      if (error_count <= 10) begin
        $display("ERROR: result %0d arrived with none owed, got %h", results_seen, act);
      end
    end else begin
      exp = bus_results_due.pop_front();
      diff = "";
      if (act.scl_level !== exp.scl_level) diff = {diff, " scl_level"};
      if (act.sda_level !== exp.sda_level) diff = {diff, " sda_level"};
      if (act.sda_drive !== exp.sda_drive) diff = {diff, " sda_drive"};
      if (act.protect_pin !== exp.protect_pin) diff = {diff, " protect_pin"};
      if (act.read_byte !== exp.read_byte) diff = {diff, " read_byte"};
      if (act.read_valid !== exp.read_valid) diff = {diff, " read_valid"};
      if (act.read_last !== exp.read_last) diff = {diff, " read_last"};
      if (act.want_byte !== exp.want_byte) diff = {diff, " want_byte"};
      if (act.busy_res !== exp.busy_res) diff = {diff, " busy_res"};
      if (act.finished !== exp.finished) diff = {diff, " finished"};
      if (act.outcome !== exp.outcome) diff = {diff, " outcome"};
      if (diff != "") begin
        error_count++;
        if (error_count <= 10) begin
          $display("ERROR: result %0d differs in%s: expected %h, got %h",
                   results_seen, diff, exp, act);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_t act;
    result_t pred;
    item_t   it;
    if (rst) begin
      wctrl = 8'd160;
      rctrl = 8'd161;
      wait_ticks = 20'd100000;
      phase = PH_IDLE;
      bits_sent = '0;
      shreg = '0;
      ee_addr = '0;
      left_total = '0;
      chunk_size = '0;
      chunk_fill = '0;
      tries = '0;
      got_nack = 1'b0;
      wait_left = '0;
      rd_req = 1'b0;
      slot = '0;
      drive_lines(1'b1, 1'b1, 1'b1);
      bus_results_due.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WRITE_CTRL: wctrl = cfg_data[7:0];
          CFG_READ_CTRL:  rctrl = cfg_data[7:0];
          CFG_WAIT_TICKS: wait_ticks = cfg_data;
          default: ;
        endcase
      end
      // Result side first: an item accepted now cannot have its result yet.
      if (m_tvalid && m_tready) begin
        act.scl_level   = m_tdata[0];
        act.sda_level   = m_tdata[1];
        act.sda_drive   = m_tdata[2];
        act.protect_pin = m_tdata[3];
        act.read_byte   = m_tdata[11:4];
        act.want_byte   = m_tdata[12];
        act.busy_res    = m_tdata[13];
        act.finished    = m_tdata[14];
        act.outcome     = outcome_t'(m_tdata[16:15]);
        act.read_valid  = m_tuser;
        act.read_last   = m_tlast;
        check_result(act);
      end
      // Input side.
      if (s_tvalid && s_tready) begin
        it.op          = op_t'(s_tuser);
        it.mem_address = s_tdata[11:0];
        it.byte_count  = s_tdata[24:12];
        it.write_byte  = s_tdata[32:25];
        it.sda_sample  = s_tdata[33];
        step_eeprom_master(it, pred);
        bus_results_due.push_back(pred);
      end
    end
    results_owed = bus_results_due.size();
    seq_idle = (phase == PH_IDLE);
    seq_wants_byte = (phase == PH_FILL);
  end

endmodule

// File: verif/tb_i2c_eeprom_paged_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C EEPROM paged master testbench
// Drives requests, page bytes and bus ticks into the paged master, with the
// acknowledge and read data levels made up per request. A directed part
// covers rejects, the memory end, a page split and failed retries; random
// requests follow over several register settings and idling patterns. The
// checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_paged_master;
  import i2cep_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int ITEMS_PER_PHASE = 70;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WAIT_W-1:0]     cfg_data;

  int   error_count;
  int   results_owed;
  logic seq_idle;
  logic seq_wants_byte;

  int   src_gap_pct;
  int   sink_stall_pct;
  int   noise_pct;
  bit   reads_only;
  int   items_sent;
  int   phase_end;
  int   cycle_count;

  i2c_eeprom_paged_master uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cep_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .results_owed   (results_owed),
    .seq_idle       (seq_idle),
    .seq_wants_byte (seq_wants_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side backpressure.
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Item with every field random; callers set the operation.
  function automatic item_t random_item();
    item_t it;
    it.op = OP_TICK;
    it.mem_address = 12'($urandom);
    it.byte_count = 13'($urandom_range(0, 4096));
    it.write_byte = 8'($urandom);
    it.sda_sample = 1'($urandom);
    return it;
  endfunction

  // Presents one item after a random gap and returns at the falling edge
  // after it was taken. Valid stays high until a caller lowers it.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, it.sda_sample, it.write_byte, it.byte_count, it.mem_address};
    s_tuser <= it.op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stops sending and waits until every owed result has come.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WAIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only with the block idle and the pipeline empty.
  task automatic configure(input logic [7:0] wc, input logic [7:0] rc,
                           input logic [WAIT_W-1:0] wt);
    drain_results();
    repeat (4) @(negedge clk);
    write_reg(CFG_WRITE_CTRL, WAIT_W'(wc));
    write_reg(CFG_READ_CTRL, WAIT_W'(rc));
    write_reg(CFG_WAIT_TICKS, wt);
    cfg_valid <= 1'b0;
  endtask

  // Issues one request and feeds bytes and ticks until the block is idle.
  // Acknowledges of a write come back high at nack_pm per thousand; read
  // data is random.
  task automatic run_request(input op_t op, input int addr, input int count,
                             input int nack_pm);
    item_t it;
    it = random_item();
    it.op = op;
    it.mem_address = 12'(addr);
    it.byte_count = 13'(count);
    send_item(it);
    while (!seq_idle) begin
      it = random_item();
      if ($urandom_range(0, 99) < noise_pct) it.op = op_t'($urandom_range(0, 3));
      else if (seq_wants_byte) it.op = OP_BYTE;
      else it.op = OP_TICK;
      if (op == OP_WRITE) it.sda_sample = ($urandom_range(0, 999) < nack_pm);
      send_item(it);
    end
  endtask

  // Random request: mostly one or two bytes, some rejects, a few longer ones.
  task automatic run_random_request();
    op_t op;
    int  addr;
    int  count;
    int  sel;
    int  pick;
    int  nack_pm;
    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    addr = $urandom_range(0, 4095);
    sel = $urandom_range(0, 99);
    if (sel < 10 || (reads_only && op == OP_WRITE)) begin
      if (addr == 0 || $urandom_range(0, 3) == 0) count = 0;
      else count = $urandom_range(4097 - addr, 4096);
    end else begin
      if (sel < 80) count = $urandom_range(1, 2);
      else count = $urandom_range(3, 4);
      if (count > 4096 - addr) count = 4096 - addr;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) nack_pm = 0;
    else if (pick < 7) nack_pm = 100;
    else if (pick < 9) nack_pm = 400;
    else nack_pm = 1000;
    run_request(op, addr, count, nack_pm);
  endtask

  initial begin
    item_t it;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    noise_pct = 5;
    reads_only = 1'b0;
    items_sent = 0;
    phase_end = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Read of the last byte with the control bytes left at their reset values.
    run_request(OP_READ, 4095, 1, 0);

    // Directed requests with a zero write wait.
    configure(8'hA0, 8'hA1, '0);
    run_request(OP_WRITE, 0, 0, 0);
    run_request(OP_READ, 4095, 0, 0);
    run_request(OP_WRITE, 1, 4096, 0);
    run_request(OP_READ, 4095, 2, 0);
    run_request(OP_WRITE, 30, 3, 0);
    run_request(OP_WRITE, 100, 1, 1000);

    // Random phases over register settings and idling patterns.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct = 58;
          sink_stall_pct = 0;
        end
        2: begin
          src_gap_pct = 0;
          sink_stall_pct = 58;
        end
        default: begin
          src_gap_pct = 9;
          sink_stall_pct = 9;
        end
      endcase
      // The longest write wait is only set while writes are all rejected.
      reads_only = (p == 3);
      if (p == 0) configure(8'h00, 8'hFF, '0);
      else if (p == 1) configure(8'hFF, 8'h00, 20'd1);
      else if (p == 2) configure(8'($urandom), 8'($urandom), 20'($urandom_range(0, 5)));
      else configure(8'($urandom), 8'($urandom), 20'hFFFFF);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 24) == 0) drain_results();
        if ($urandom_range(0, 99) < noise_pct) begin
          // Idle noise: ticks and unwanted bytes.
          it = random_item();
          it.op = $urandom_range(0, 1) ? OP_TICK : OP_BYTE;
          send_item(it);
        end
        run_random_request();
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
